// File: src/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the symbol frequency sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

	localparam int ALPHABET    = 64;
	localparam int COUNT_WIDTH = 16;
	localparam int SYM_W       = 6;
	localparam int OUT_CNT_W   = 16;
	localparam int MEM_DEPTH   = 2 ** SYM_W;
	localparam int NUM_W       = SYM_W + 1;
	localparam int KEY_W       = COUNT_WIDTH + SYM_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [SYM_W-1:0]       sym_t;
	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [NUM_W-1:0]       num_t;
	typedef logic [KEY_W-1:0]       key_t;
	typedef logic [OUT_CNT_W-1:0]   out_cnt_t;

	localparam cnt_t     CNT_MAX     = '1;
	localparam out_cnt_t OUT_CNT_MAX = '1;

	typedef struct packed {
		sym_t sym;
		logic in_range;
		logic eos;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		ST_COUNT,
		ST_DRAIN,
		ST_START,
		ST_SCAN,
		ST_EMIT
	} state_t;

	function automatic out_cnt_t clamp_count(input cnt_t c);
		logic [31:0] w;
		w = 32'(c);
		if (w > 32'(OUT_CNT_MAX))
			return OUT_CNT_MAX;
		return out_cnt_t'(w);
	endfunction

endpackage

`default_nettype wire

// File: src/sfs_front.sv
// ----------------------------------------------------------------------------
// sfs_front
// Input register: accepts a transaction, tags out-of-alphabet symbols and
// hands the item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire sfs_pkg::sym_t  symbol,
	input  wire logic           end_of_set,
	output logic                busy,
	input  wire sfs_pkg::q_stat_t q_stat,
	output logic                push,
	output sfs_pkg::item_t      push_item
);

	sfs_pkg::item_t item_q;
	logic           item_vld_q;
	logic           accept;

	assign push      = item_vld_q && !q_stat.full;
	assign busy      = item_vld_q && q_stat.full;
	assign accept    = start && !busy;
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_q <= 1'b0;
		end else if (accept) begin
			item_vld_q <= 1'b1;
		end else if (push) begin
			item_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.sym      <= symbol;
			item_q.in_range <= {1'b0, symbol} < sfs_pkg::NUM_W'(sfs_pkg::ALPHABET);
			item_q.eos      <= end_of_set;
		end
	end

endmodule

`default_nettype wire

// File: src/sfs_queue.sv
// ----------------------------------------------------------------------------
// sfs_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sfs_pkg::item_t   push_item,
	input  wire logic             pop,
	output sfs_pkg::item_t        head,
	output sfs_pkg::q_stat_t      stat
);

	sfs_pkg::item_t                entry_q [sfs_pkg::QUEUE_DEPTH];
	logic [sfs_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sfs_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sfs_pkg::QPTR_W:0]      fill_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = fill_q == (sfs_pkg::QPTR_W + 1)'(sfs_pkg::QUEUE_DEPTH);
	assign stat.empty = fill_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

// File: src/sfs_back.sv
// ----------------------------------------------------------------------------
// sfs_back
// Histogram update, selection scan over the histogram and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfs_pkg::item_t    head,
	input  wire sfs_pkg::q_stat_t  q_stat,
	output logic                   pop,
	output logic                   out_strobe,
	output sfs_pkg::sym_t          out_symbol,
	output sfs_pkg::out_cnt_t      out_count,
	output logic                   last_result
);

	sfs_pkg::state_t state_q, state_d;

	sfs_pkg::cnt_t                  hist_mem [sfs_pkg::MEM_DEPTH];
	sfs_pkg::cnt_t                  rd_q;
	logic [sfs_pkg::MEM_DEPTH-1:0]  vbit_q;
	sfs_pkg::num_t                  distinct_q;
	sfs_pkg::num_t                  emitted_q;

	logic           c_vld_s1;
	sfs_pkg::item_t c_item_s1;
	logic           byp_s1;
	sfs_pkg::cnt_t  byp_data_s1;
	sfs_pkg::cnt_t  c_old;
	sfs_pkg::cnt_t  c_new;
	logic           c_wr;

	sfs_pkg::sym_t  rd_addr;
	sfs_pkg::sym_t  scan_idx_q;
	logic           scan_act_q;
	logic           scan_issue;
	logic           sv_vld_s1;
	logic           sv_last_s1;
	logic           sv_bit_s1;
	sfs_pkg::sym_t  sv_sym_s1;

	sfs_pkg::key_t  cand_key;
	sfs_pkg::key_t  best_key_q;
	sfs_pkg::key_t  last_key_q;
	logic           have_best_q;
	logic           have_last_q;
	logic           take;
	logic           emit_last;

	assign pop        = (state_q == sfs_pkg::ST_COUNT) && !q_stat.empty;
	assign c_wr       = c_vld_s1 && c_item_s1.in_range;
	assign c_old      = !vbit_q[c_item_s1.sym] ? '0 : (byp_s1 ? byp_data_s1 : rd_q);
	assign c_new      = (c_old == sfs_pkg::CNT_MAX) ? c_old : c_old + 1'b1;
	assign scan_issue = (state_q == sfs_pkg::ST_SCAN) && scan_act_q;
	assign rd_addr    = (state_q == sfs_pkg::ST_SCAN) ? scan_idx_q : head.sym;
	assign cand_key   = {rd_q, sv_sym_s1};
	assign take       = sv_vld_s1 && sv_bit_s1
		&& (!have_last_q || cand_key > last_key_q)
		&& (!have_best_q || cand_key < best_key_q);
	assign emit_last  = sfs_pkg::num_t'(emitted_q + 1'b1) == distinct_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfs_pkg::ST_COUNT: begin
				if (pop && head.eos)
					state_d = sfs_pkg::ST_DRAIN;
			end
			sfs_pkg::ST_DRAIN: begin
				state_d = sfs_pkg::ST_START;
			end
			sfs_pkg::ST_START: begin
				state_d = (distinct_q == '0) ? sfs_pkg::ST_COUNT : sfs_pkg::ST_SCAN;
			end
			sfs_pkg::ST_SCAN: begin
				if (sv_vld_s1 && sv_last_s1)
					state_d = sfs_pkg::ST_EMIT;
			end
			sfs_pkg::ST_EMIT: begin
				state_d = emit_last ? sfs_pkg::ST_COUNT : sfs_pkg::ST_SCAN;
			end
			default: begin
				state_d = sfs_pkg::ST_COUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfs_pkg::ST_COUNT;
			c_vld_s1    <= 1'b0;
			vbit_q      <= '0;
			distinct_q  <= '0;
			emitted_q   <= '0;
			scan_idx_q  <= '0;
			scan_act_q  <= 1'b0;
			sv_vld_s1   <= 1'b0;
			have_best_q <= 1'b0;
			have_last_q <= 1'b0;
			out_strobe  <= 1'b0;
		end else begin
			state_q    <= state_d;
			c_vld_s1   <= pop;
			sv_vld_s1  <= scan_issue;
			out_strobe <= state_q == sfs_pkg::ST_EMIT;
			if (c_wr) begin
				vbit_q[c_item_s1.sym] <= 1'b1;
				if (!vbit_q[c_item_s1.sym])
					distinct_q <= distinct_q + 1'b1;
			end
			if (take)
				have_best_q <= 1'b1;
			if (scan_issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_idx_q == sfs_pkg::SYM_W'(sfs_pkg::ALPHABET - 1))
					scan_act_q <= 1'b0;
			end
			if (state_q == sfs_pkg::ST_START) begin
				scan_idx_q  <= '0;
				scan_act_q  <= 1'b1;
				have_best_q <= 1'b0;
				have_last_q <= 1'b0;
				emitted_q   <= '0;
			end
			if (state_q == sfs_pkg::ST_EMIT) begin
				have_last_q <= 1'b1;
				have_best_q <= 1'b0;
				emitted_q   <= emitted_q + 1'b1;
				scan_idx_q  <= '0;
				if (emit_last) begin
					vbit_q     <= '0;
					distinct_q <= '0;
				end else begin
					scan_act_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= hist_mem[rd_addr];
		if (c_wr)
			hist_mem[c_item_s1.sym] <= c_new;
		if (pop) begin
			c_item_s1   <= head;
			byp_s1      <= c_wr && (c_item_s1.sym == head.sym);
			byp_data_s1 <= c_new;
		end
		sv_sym_s1  <= scan_idx_q;
		sv_last_s1 <= scan_idx_q == sfs_pkg::SYM_W'(sfs_pkg::ALPHABET - 1);
		sv_bit_s1  <= vbit_q[scan_idx_q];
		if (take)
			best_key_q <= cand_key;
		if (state_q == sfs_pkg::ST_EMIT) begin
			last_key_q  <= best_key_q;
			out_symbol  <= best_key_q[sfs_pkg::SYM_W-1:0];
			out_count   <= sfs_pkg::clamp_count(best_key_q[sfs_pkg::KEY_W-1:sfs_pkg::SYM_W]);
			last_result <= emit_last;
		end
	end

endmodule

`default_nettype wire

// File: src/symbol_frequency_sorter_core.sv
// ----------------------------------------------------------------------------
// symbol_frequency_sorter_core
// Counts symbols into a histogram and emits the present symbols ordered by
// ascending count, ties by ascending symbol.
// ----------------------------------------------------------------------------
// Counting: one transaction per cycle while busy is low, limited by the
// single histogram port. After the end-of-set transaction, each result takes
// one selection scan over the histogram. busy rises when the 4-entry queue
// fills. Results are strobed for one cycle and cannot be stalled.
// Reset clears the histogram valid bits at once; no clearing pass is needed.
`default_nettype none

module symbol_frequency_sorter_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire sfs_pkg::sym_t     symbol,
	input  wire logic              end_of_set,
	output logic                   out_strobe,
	output sfs_pkg::sym_t          out_symbol,
	output sfs_pkg::out_cnt_t      out_count,
	output logic                   last_result
);

	logic             q_push;
	logic             q_pop;
	sfs_pkg::item_t   q_push_item;
	sfs_pkg::item_t   q_head;
	sfs_pkg::q_stat_t q_stat;

	sfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.symbol    (symbol),
		.end_of_set(end_of_set),
		.busy      (busy),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_item (q_push_item)
	);

	sfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_push_item),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	sfs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_stat     (q_stat),
		.pop        (q_pop),
		.out_strobe (out_strobe),
		.out_symbol (out_symbol),
		.out_count  (out_count),
		.last_result(last_result)
	);

	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |=> !out_strobe)
		else $error("results strobed in consecutive cycles");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |-> out_count != '0)
		else $error("result with zero count");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");

	a_busy_queue: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !q_stat.empty)
		else $error("busy with empty queue");

endmodule

`default_nettype wire

// File: dv/symbol_frequency_sorter_core_tb.sv
// ----------------------------------------------------------------------------
// symbol_frequency_sorter_core_tb
// Streams data sets of symbols into the sorter with random idle gaps and
// checks every strobed entry against a local histogram predictor that sorts
// present symbols by ascending count, ties by ascending symbol. Covers single
// symbol sets, ties and a full-alphabet run.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_frequency_sorter_core_tb;

	localparam int          RAND_ITEMS = 320;
	localparam int          TAIL       = 2 * (sfs_pkg::ALPHABET + 8);
	localparam longint      LIMIT      = 5_000_000;

	typedef struct {
		sfs_pkg::sym_t sym;
		logic          eos;
		bit            drain;
		int unsigned   gap;
	} stim_t;

	typedef struct {
		sfs_pkg::sym_t     sym;
		sfs_pkg::out_cnt_t count;
		logic              last;
	} entry_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              start      = 1'b0;
	sfs_pkg::sym_t     symbol     = '0;
	logic              end_of_set = 1'b0;
	logic              busy;
	logic              out_strobe;
	sfs_pkg::sym_t     out_symbol;
	sfs_pkg::out_cnt_t out_count;
	logic              last_result;

	stim_t         pending[$];
	entry_t        sorted_q[$];
	sfs_pkg::cnt_t tally[sfs_pkg::ALPHABET];
	int unsigned   idle_left;
	int            n_items;
	int            n_sent;
	int            n_sets;
	int            n_checked;
	int            errors;
	longint        cycles;

	symbol_frequency_sorter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.symbol     (symbol),
		.end_of_set (end_of_set),
		.out_strobe (out_strobe),
		.out_symbol (out_symbol),
		.out_count  (out_count),
		.last_result(last_result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic void add_item(input int s, input bit eos, input bit drain,
			input int unsigned gap);
		stim_t it;
		it.sym   = sfs_pkg::sym_t'(s);
		it.eos   = eos;
		it.drain = drain;
		it.gap   = gap;
		pending.push_back(it);
		n_items++;
	endfunction

	// count one symbol; on end of set emit the sorted run and clear
	function automatic void count_symbol(input sfs_pkg::sym_t s, input logic eos);
		bit     taken[sfs_pkg::ALPHABET];
		int     n_left;
		int     pick;
		entry_t e;
		if (int'(s) < sfs_pkg::ALPHABET && tally[s] != sfs_pkg::CNT_MAX)
			tally[s]++;
		if (!eos)
			return;
		n_left = 0;
		for (int i = 0; i < sfs_pkg::ALPHABET; i++)
			if (tally[i] != 0)
				n_left++;
		while (n_left > 0) begin
			pick = -1;
			for (int i = 0; i < sfs_pkg::ALPHABET; i++)
				if (tally[i] != 0 && !taken[i] && (pick < 0 || tally[i] < tally[pick]))
					pick = i;
			taken[pick] = 1'b1;
			n_left--;
			e.sym   = sfs_pkg::sym_t'(pick);
			e.count = (tally[pick] > sfs_pkg::OUT_CNT_MAX) ? sfs_pkg::OUT_CNT_MAX
				: sfs_pkg::out_cnt_t'(tally[pick]);
			e.last  = (n_left == 0);
			sorted_q.push_back(e);
		end
		for (int i = 0; i < sfs_pkg::ALPHABET; i++)
			tally[i] = '0;
	endfunction

	always @(posedge clk) begin
		stim_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				count_symbol(symbol, end_of_set);
				n_sent++;
				if (end_of_set)
					n_sets++;
			end
			if (start && busy) begin
				// hold the current transaction
			end else if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (pending.size() > 0 && !(pending[0].drain && sorted_q.size() != 0)) begin
				nxt = pending.pop_front();
				symbol     <= nxt.sym;
				end_of_set <= nxt.eos;
				start      <= 1'b1;
				idle_left  = nxt.gap;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		entry_t e;
		if (arst_n && out_strobe) begin
			if (sorted_q.size() == 0) begin
				$error("result with nothing expected: symbol %0d count %0d last %0b",
					out_symbol, out_count, last_result);
				errors++;
			end else begin
				e = sorted_q.pop_front();
				n_checked++;
				if (out_symbol !== e.sym) begin
					$error("out_symbol expected %0d actual %0d", e.sym, out_symbol);
					errors++;
				end
				if (out_count !== e.count) begin
					$error("out_count expected %0d actual %0d", e.count, out_count);
					errors++;
				end
				if (last_result !== e.last) begin
					$error("last_result expected %0b actual %0b", e.last, last_result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[symbol_frequency_sorter_core] ERROR");
			$finish;
		end
	end

	initial begin
		int    perm[sfs_pkg::ALPHABET];
		int    j;
		int    t;
		int    len;
		int    lo;
		int    n_rand;
		bit    narrow;
		bit    quiet;
		bit    drain;

		// single symbol sets at both ends of the alphabet
		add_item(0, 1'b1, 1'b0, 0);
		add_item(63, 1'b1, 1'b0, idle_gap());
		// mixed counts with a three-way tie
		add_item(63, 1'b0, 1'b0, 0);
		add_item(0, 1'b0, 1'b0, 0);
		add_item(42, 1'b0, 1'b0, 1);
		add_item(21, 1'b0, 1'b0, 0);
		add_item(63, 1'b0, 1'b0, 0);
		add_item(42, 1'b0, 1'b0, 2);
		add_item(0, 1'b0, 1'b0, 0);
		add_item(21, 1'b0, 1'b0, 0);
		add_item(1, 1'b0, 1'b0, 0);
		add_item(63, 1'b1, 1'b0, 0);
		// higher symbol with lower count comes first
		add_item(42, 1'b0, 1'b1, 0);
		add_item(21, 1'b0, 1'b0, 0);
		add_item(21, 1'b0, 1'b0, 0);
		add_item(21, 1'b1, 1'b0, 0);
		// alternating bit patterns, tie
		add_item(42, 1'b0, 1'b0, 0);
		add_item(21, 1'b1, 1'b0, 0);

		// every symbol present, shuffled, with a few repeats
		for (int i = 0; i < sfs_pkg::ALPHABET; i++)
			perm[i] = i;
		for (int i = sfs_pkg::ALPHABET - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < 8; i++)
			add_item($urandom_range(0, 63), 1'b0, i == 0, idle_gap());
		for (int i = 0; i < sfs_pkg::ALPHABET; i++)
			add_item(perm[i], i == sfs_pkg::ALPHABET - 1, 1'b0, idle_gap());

		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			len    = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 12);
			lo     = $urandom_range(0, 63);
			narrow = $urandom_range(0, 1);
			quiet  = ($urandom_range(0, 3) == 0);
			drain  = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < len; i++) begin
				t = narrow ? lo + $urandom_range(0, (63 - lo < 3) ? 63 - lo : 3)
					: $urandom_range(0, 63);
				add_item(t, i == len - 1, drain && i == 0, quiet ? 0 : idle_gap());
			end
			n_rand += len;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent != n_items)
			@(posedge clk);
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		$display("sent %0d symbols in %0d data sets, checked %0d sorted entries",
			n_sent, n_sets, n_checked);
		$display("sets ranged from single symbols and ties to a full-alphabet run");
		if (errors == 0)
			$display("[symbol_frequency_sorter_core] OK");
		else
			$display("[symbol_frequency_sorter_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
src/sfs_pkg.sv
src/sfs_front.sv
src/sfs_queue.sv
src/sfs_back.sv
src/symbol_frequency_sorter_core.sv
dv/symbol_frequency_sorter_core_tb.sv
